// ===== design/rbsi_pkg.sv =====
// Shared definitions for the ray/box slab intersection block.
// Register map codes and the stage-advance bundle used by the plane units.
// No dependencies.
`default_nettype none

package rbsi_pkg;

    localparam int NUM_REGS = 6;

    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    // per-stage load enables for the plane distance pipeline
    typedef struct packed {
        logic load_diff;
        logic load_pp;
        logic load_prod;
        logic load_dist;
    } rbsi_adv_t;

endpackage

`default_nettype wire

// ===== design/rbsi_if.sv =====
// Ray input and result output channels (valid/ready beats).
// Depends on nothing; width follows COORD_WIDTH.
`default_nettype none

interface rbsi_ray_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] inv_dir_x;
    logic signed [COORD_WIDTH-1:0] inv_dir_y;
    logic signed [COORD_WIDTH-1:0] inv_dir_z;
    logic [2:0]                    sign_mask;

    modport source (
        output valid, origin_x, origin_y, origin_z,
        output inv_dir_x, inv_dir_y, inv_dir_z, sign_mask,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z,
        input  inv_dir_x, inv_dir_y, inv_dir_z, sign_mask,
        output ready
    );
endinterface

interface rbsi_hit_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] hit_distance;

    modport source (
        output valid, hit, hit_distance,
        input  ready
    );
    modport sink (
        input  valid, hit, hit_distance,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/rbsi_plane_dist.sv =====
// One plane distance unit: (plane - origin) * inv_dir >> FRAC_BITS, floor, saturated.
// Four register stages; uses rbsi_pkg::rbsi_adv_t for stage loads.
`default_nettype none

module rbsi_plane_dist #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire rbsi_pkg::rbsi_adv_t           adv,
    input  wire logic signed [COORD_WIDTH-1:0] plane,
    input  wire logic signed [COORD_WIDTH-1:0] origin,
    input  wire logic signed [COORD_WIDTH-1:0] inv_dir,
    output logic signed [COORD_WIDTH-1:0]      distance
);

    localparam int W  = COORD_WIDTH;
    localparam int H  = W / 2;
    localparam int L  = W - H;
    localparam int PW = 2 * W;
    localparam int QW = PW + 1 - FRAC_BITS;
    localparam int CW = PW + 2;

    // stage 1: sign/magnitude of difference and inverse direction
    logic signed [W:0] diff;
    logic [W:0]        diff_neg;
    logic [W-1:0]      dm_next, im_next;
    logic              neg_next;
    logic [W-1:0]      dm_reg, im_reg;
    logic              neg1_reg;

    assign diff     = {plane[W-1], plane} - {origin[W-1], origin};
    assign diff_neg = -diff;
    assign dm_next  = diff[W] ? diff_neg[W-1:0] : diff[W-1:0];
    assign im_next  = inv_dir[W-1] ? (~inv_dir + W'(1)) : inv_dir;
    assign neg_next = diff[W] ^ inv_dir[W-1];

    always_ff @(posedge clk)
    begin
        if (adv.load_diff)
        begin
            dm_reg   <= dm_next;
            im_reg   <= im_next;
            neg1_reg <= neg_next;
        end
    end

    // stage 2: two partial products on halves of the inverse magnitude
    logic [W+H-1:0] pl_next, pl_reg;
    logic [W+L-1:0] ph_next, ph_reg;
    logic           neg2_reg;

    assign pl_next = {{H{1'b0}}, dm_reg} * {{W{1'b0}}, im_reg[H-1:0]};
    assign ph_next = {{L{1'b0}}, dm_reg} * {{W{1'b0}}, im_reg[W-1:H]};

    always_ff @(posedge clk)
    begin
        if (adv.load_pp)
        begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: full product
    logic [PW-1:0] prod_next, prod_reg;
    logic          neg3_reg;

    assign prod_next = {{L{1'b0}}, pl_reg} + ({{H{1'b0}}, ph_reg} << H);

    always_ff @(posedge clk)
    begin
        if (adv.load_prod)
        begin
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
        end
    end

    // stage 4: scale back, round toward minus infinity, saturate
    logic [PW:0]   prodx;
    logic [QW-1:0] quot;
    logic          rem_nz;
    logic [CW-1:0] qr, lim_neg, lim_pos;
    logic          big;
    logic [W-1:0]  mag;
    logic signed [W-1:0] dist_next, dist_reg;

    assign prodx   = {1'b0, prod_reg};
    assign quot    = prodx[PW:FRAC_BITS];
    assign rem_nz  = |prod_reg[FRAC_BITS-1:0];
    assign qr      = {{(CW-QW){1'b0}}, quot} + CW'(neg3_reg && rem_nz);
    assign lim_neg = CW'(1) << (W - 1);
    assign lim_pos = lim_neg - CW'(1);
    assign big     = neg3_reg ? (qr > lim_neg) : (qr > lim_pos);
    assign mag     = qr[W-1:0];

    always_comb
    begin
        if (big)
            dist_next = neg3_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            dist_next = neg3_reg ? -mag : mag;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_dist)
            dist_reg <= dist_next;
    end

    assign distance = dist_reg;

endmodule

`default_nettype wire

// ===== design/ray_box_slab_intersect.sv =====
// Ray against axis-aligned box slab test, top level.
// Uses rbsi_pkg, rbsi_if.sv interfaces and rbsi_plane_dist.
//
// Usage:
//   Box corners are written over the APB port (min x/y/z, max x/y/z at
//   byte offsets 0..20 by 4 up to 32-bit coordinates, 0..40 by 8 above).
//   Writes take effect at the access cycle; pready is tied high. Reads
//   return the sign-extended register.
//   Rays arrive as beats on 'ray' (origin, inverse direction, sign mask);
//   one result beat per ray leaves on 'res' (hit flag, distance, 0 on miss).
// Pipeline / throughput:
//   Six register stages: difference, partial products, product, round and
//   saturate, x/y interval merge, z merge and result select. One ray per
//   cycle sustained while 'res' is ready; the rate is set by the six plane
//   distance units (two 1/2-width multipliers each), one per near/far plane
//   per axis, all working in parallel.
// Reset:
//   rst_n clears all stage valid bits and the box registers to 0.
// Stall:
//   Each stage advances when it is empty or the next one advances, so
//   bubbles close up while 'res' is stalled; ray.ready drops only once all
//   six stages hold beats. Nothing is lost or repeated.
`default_nettype none

module ray_box_slab_intersect #(
    parameter  int COORD_WIDTH = 32,
    parameter  int FRAC_BITS   = 16,
    localparam int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_LSB    = (COORD_WIDTH > 32) ? 3 : 2,
    localparam int ADDR_W      = ADDR_LSB + 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    rbsi_ray_if.sink               ray,
    rbsi_hit_if.source             res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int W      = COORD_WIDTH;
    localparam int STAGES = 6;

    // ---------------- configuration registers ----------------
    logic signed [W-1:0] box_reg [rbsi_pkg::NUM_REGS];
    logic [2:0]          reg_idx;
    logic                cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rbsi_pkg::NUM_REGS; i++)
                box_reg[i] <= '0;
        end
        else if (cfg_wr && (reg_idx < 3'(rbsi_pkg::NUM_REGS)))
        begin
            box_reg[reg_idx] <= pwdata[W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx < 3'(rbsi_pkg::NUM_REGS))
            prdata = DATA_W'(box_reg[reg_idx]);
        else
            prdata = '0;
    end

    // ---------------- stage valid bits and advance ----------------
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv_en;

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        adv_en[STAGES-1] = !vld_reg[STAGES-1] || res.ready;
        for (int i = STAGES - 2; i >= 0; i--)
            adv_en[i] = !vld_reg[i] || adv_en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv_en[0])
                vld_reg[0] <= ray.valid;
            for (int i = 1; i < STAGES; i++)
                if (adv_en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign ray.ready = adv_en[0];

    rbsi_pkg::rbsi_adv_t pd_adv;

    assign pd_adv.load_diff = adv_en[0];
    assign pd_adv.load_pp   = adv_en[1];
    assign pd_adv.load_prod = adv_en[2];
    assign pd_adv.load_dist = adv_en[3];

    // ---------------- plane distances (stages 1-4) ----------------
    // A set sign bit swaps the slab: max corner is the near plane.
    logic signed [W-1:0] near_x, far_x, near_y, far_y, near_z, far_z;

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_near_x (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[0] ? box_reg[rbsi_pkg::REG_BOX_MAX_X]
                                    : box_reg[rbsi_pkg::REG_BOX_MIN_X]),
        .origin   (ray.origin_x),
        .inv_dir  (ray.inv_dir_x),
        .distance (near_x)
    );

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_far_x (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[0] ? box_reg[rbsi_pkg::REG_BOX_MIN_X]
                                    : box_reg[rbsi_pkg::REG_BOX_MAX_X]),
        .origin   (ray.origin_x),
        .inv_dir  (ray.inv_dir_x),
        .distance (far_x)
    );

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_near_y (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[1] ? box_reg[rbsi_pkg::REG_BOX_MAX_Y]
                                    : box_reg[rbsi_pkg::REG_BOX_MIN_Y]),
        .origin   (ray.origin_y),
        .inv_dir  (ray.inv_dir_y),
        .distance (near_y)
    );

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_far_y (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[1] ? box_reg[rbsi_pkg::REG_BOX_MIN_Y]
                                    : box_reg[rbsi_pkg::REG_BOX_MAX_Y]),
        .origin   (ray.origin_y),
        .inv_dir  (ray.inv_dir_y),
        .distance (far_y)
    );

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_near_z (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[2] ? box_reg[rbsi_pkg::REG_BOX_MAX_Z]
                                    : box_reg[rbsi_pkg::REG_BOX_MIN_Z]),
        .origin   (ray.origin_z),
        .inv_dir  (ray.inv_dir_z),
        .distance (near_z)
    );

    rbsi_plane_dist #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_far_z (
        .clk      (clk),
        .adv      (pd_adv),
        .plane    (ray.sign_mask[2] ? box_reg[rbsi_pkg::REG_BOX_MIN_Z]
                                    : box_reg[rbsi_pkg::REG_BOX_MAX_Z]),
        .origin   (ray.origin_z),
        .inv_dir  (ray.inv_dir_z),
        .distance (far_z)
    );

    // ---------------- stage 5: merge x and y slabs ----------------
    logic signed [W-1:0] tmin_next, tmax_next;
    logic                miss_next;
    logic signed [W-1:0] tmin_reg, tmax_reg, near_z_reg, far_z_reg;
    logic                miss_reg;

    assign miss_next = (near_x > far_y) || (near_y > far_x);
    assign tmin_next = (near_y > near_x) ? near_y : near_x;
    assign tmax_next = (far_y < far_x) ? far_y : far_x;

    always_ff @(posedge clk)
    begin
        if (adv_en[4])
        begin
            tmin_reg   <= tmin_next;
            tmax_reg   <= tmax_next;
            miss_reg   <= miss_next;
            near_z_reg <= near_z;
            far_z_reg  <= far_z;
        end
    end

    // ---------------- stage 6: merge z slab, pick distance ----------------
    logic signed [W-1:0] tmin_z, tmax_z;
    logic                miss_z;
    logic                hit_next;
    logic signed [W-1:0] dist_next;
    logic                hit_reg;
    logic signed [W-1:0] dist_reg;

    assign miss_z = miss_reg || (tmin_reg > far_z_reg) || (near_z_reg > tmax_reg);
    assign tmin_z = (near_z_reg > tmin_reg) ? near_z_reg : tmin_reg;
    assign tmax_z = (far_z_reg < tmax_reg) ? far_z_reg : tmax_reg;

    // interval wholly behind the origin is a miss; inside the box reports exit
    always_comb
    begin
        if (miss_z || (tmin_z[W-1] && tmax_z[W-1]))
        begin
            hit_next  = 1'b0;
            dist_next = '0;
        end
        else
        begin
            hit_next  = 1'b1;
            dist_next = tmin_z[W-1] ? tmax_z : tmin_z;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_en[5])
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign res.valid        = vld_reg[STAGES-1];
    assign res.hit          = hit_reg;
    assign res.hit_distance = dist_reg;

endmodule

`default_nettype wire

// ===== design/rbsi_checker.sv =====
// Port-level checks for ray_box_slab_intersect, bound to the top level.
// Depends on ray_box_slab_intersect and rbsi_if.sv.
`default_nettype none

module rbsi_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   hit,
    input wire logic [COORD_WIDTH-1:0] hit_distance
);

    // a miss always carries distance 0
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0)
        else $error("miss beat with nonzero distance");

    // a hit is never behind the origin
    a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !hit_distance[COORD_WIDTH-1])
        else $error("hit beat with negative distance");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result beat straight out of reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance))
        else $error("stalled result beat changed");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .hit          (res.hit),
    .hit_distance (res.hit_distance)
);

`default_nettype wire
